// File: sv/lrbc_pkg.sv
// ----------------------------------------------------------------------------
// Link reconnect backoff controller package
// Shared widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package lrbc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned IDX_W   = 2;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [IDX_W-1:0] {
        REG_CONNECT_TIMEOUT = 2'd0,
        REG_RETRY_INTERVAL  = 2'd1,
        REG_COOLDOWN        = 2'd2,
        REG_ATTEMPT_LIMIT   = 2'd3
    } t_reg_idx;

    localparam t_time  RST_CONNECT_TIMEOUT = 32'd10000;
    localparam t_time  RST_RETRY_INTERVAL  = 32'd5000;
    localparam t_time  RST_COOLDOWN        = 32'd300000;
    localparam t_count RST_ATTEMPT_LIMIT   = 8'd5;
    localparam t_count COUNT_MAX           = '1;

    localparam logic KIND_POLL    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

endpackage

// File: sv/lrbc_if.sv
// ----------------------------------------------------------------------------
// Link reconnect backoff controller channels
// Input, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface lrbc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    lrbc_pkg::t_time      now_ms;
    logic                 link_up;

    modport source (output valid, kind, now_ms, link_up, input ready);
    modport sink   (input valid, kind, now_ms, link_up, output ready);
endinterface

interface lrbc_out_if;
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 start_link;
    logic                 first_start;
    logic                 drop_link;
    logic                 busy_connecting;
    logic                 in_cooldown;
    lrbc_pkg::t_count     attempt_count;

    modport source (output valid, accepted, start_link, first_start, drop_link,
                    busy_connecting, in_cooldown, attempt_count, input ready);
    modport sink   (input valid, accepted, start_link, first_start, drop_link,
                    busy_connecting, in_cooldown, attempt_count, output ready);
endinterface

interface lrbc_cfg_if;
    logic                 valid;
    logic                 ready;
    lrbc_pkg::t_reg_idx   reg_idx;
    lrbc_pkg::t_time      wdata;

    modport source (output valid, reg_idx, wdata, input ready);
    modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// File: sv/link_reconnect_backoff_controller.sv
// ----------------------------------------------------------------------------
// Link reconnect backoff controller
// Starts, abandons and retries link connection attempts with a cooldown.
// ----------------------------------------------------------------------------
// Path: the input beat is taken into the input register, then the result register;
//   the state update and decision sit between the two.
// Throughput: one beat per cycle while o_res.ready; result register frees input.
// Reset: synchronous active low; clears control state and loads the
//   register defaults (timeout 10000, retry 5000, cooldown 300000, limit 5).
module link_reconnect_backoff_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrbc_in_if.sink     i_in,
    lrbc_out_if.source  o_res,
    lrbc_cfg_if.sink    i_cfg
);

    // config registers
    lrbc_pkg::t_time  r_timeout;
    lrbc_pkg::t_time  r_retry;
    lrbc_pkg::t_time  r_cooldown_ms;
    lrbc_pkg::t_count r_limit;

    // input register
    logic             r_in_valid;
    logic             r_kind;
    lrbc_pkg::t_time  r_now;
    logic             r_up;

    // controller state
    logic             r_connecting;
    logic             r_started_once;
    lrbc_pkg::t_time  r_attempt_start;
    lrbc_pkg::t_time  r_last_attempt;
    lrbc_pkg::t_time  r_cooldown_start;
    logic             r_cooldown;
    lrbc_pkg::t_count r_attempts;

    logic             n_connecting;
    logic             n_started_once;
    lrbc_pkg::t_time  n_attempt_start;
    lrbc_pkg::t_time  n_last_attempt;
    lrbc_pkg::t_time  n_cooldown_start;
    logic             n_cooldown;
    lrbc_pkg::t_count n_attempts;

    // result register
    logic             r_out_valid;
    logic             r_started;
    logic             r_first;
    logic             r_drop;
    logic             r_busy;
    logic             r_in_cd;
    lrbc_pkg::t_count r_count;

    logic             w_fire;
    logic             w_start;
    logic             w_first;
    logic             w_drop;
    logic             w_wait;
    lrbc_pkg::t_time  w_run_time;
    lrbc_pkg::t_time  w_cd_time;
    lrbc_pkg::t_time  w_since_last;

    assign w_fire     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_fire;
    assign i_cfg.ready = 1'b1;

    assign w_run_time   = r_now - r_attempt_start;
    assign w_cd_time    = r_now - r_cooldown_start;
    assign w_since_last = r_now - r_last_attempt;

    always_comb begin
        n_connecting     = r_connecting;
        n_started_once   = r_started_once;
        n_attempt_start  = r_attempt_start;
        n_last_attempt   = r_last_attempt;
        n_cooldown_start = r_cooldown_start;
        n_cooldown       = r_cooldown;
        n_attempts       = r_attempts;
        w_start          = 1'b0;
        w_first          = 1'b0;
        w_drop           = 1'b0;
        w_wait           = 1'b0;

        if (r_kind == lrbc_pkg::KIND_REQUEST) begin
            w_start = !r_up && !r_connecting;
        end else if (r_up) begin
            n_connecting = 1'b0;
            n_attempts   = '0;
            n_cooldown   = 1'b0;
        end else if (r_connecting) begin
            if (w_run_time >= r_timeout) begin
                w_drop         = 1'b1;
                n_connecting   = 1'b0;
                n_last_attempt = r_now;
                if (r_attempts >= r_limit) begin
                    n_cooldown       = 1'b1;
                    n_cooldown_start = r_now;
                end
            end
        end else begin
            if (r_cooldown) begin
                if (w_cd_time < r_cooldown_ms) begin
                    w_wait = 1'b1;
                end else begin
                    n_attempts = '0;
                    n_cooldown = 1'b0;
                end
            end
            w_start = !w_wait && (w_since_last >= r_retry);
        end

        if (w_start) begin
            w_first         = !r_started_once;
            n_last_attempt  = r_now;
            n_attempt_start = r_now;
            n_connecting    = 1'b1;
            n_started_once  = 1'b1;
            if (n_attempts != lrbc_pkg::COUNT_MAX) begin
                n_attempts = n_attempts + lrbc_pkg::t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= lrbc_pkg::RST_CONNECT_TIMEOUT;
            r_retry       <= lrbc_pkg::RST_RETRY_INTERVAL;
            r_cooldown_ms <= lrbc_pkg::RST_COOLDOWN;
            r_limit       <= lrbc_pkg::RST_ATTEMPT_LIMIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_idx)
                lrbc_pkg::REG_CONNECT_TIMEOUT: r_timeout     <= i_cfg.wdata;
                lrbc_pkg::REG_RETRY_INTERVAL:  r_retry       <= i_cfg.wdata;
                lrbc_pkg::REG_COOLDOWN:        r_cooldown_ms <= i_cfg.wdata;
                lrbc_pkg::REG_ATTEMPT_LIMIT:
                    r_limit <= i_cfg.wdata[lrbc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_now  <= i_in.now_ms;
            r_up   <= i_in.link_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connecting     <= 1'b0;
            r_started_once   <= 1'b0;
            r_attempt_start  <= '0;
            r_last_attempt   <= '0;
            r_cooldown_start <= '0;
            r_cooldown       <= 1'b0;
            r_attempts       <= '0;
        end else if (w_fire) begin
            r_connecting     <= n_connecting;
            r_started_once   <= n_started_once;
            r_attempt_start  <= n_attempt_start;
            r_last_attempt   <= n_last_attempt;
            r_cooldown_start <= n_cooldown_start;
            r_cooldown       <= n_cooldown;
            r_attempts       <= n_attempts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_started <= w_start;
            r_first   <= w_first;
            r_drop    <= w_drop;
            r_busy    <= n_connecting;
            r_in_cd   <= n_cooldown;
            r_count   <= n_attempts;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.accepted        = r_started;
    assign o_res.start_link      = r_started;
    assign o_res.first_start     = r_first;
    assign o_res.drop_link       = r_drop;
    assign o_res.busy_connecting = r_busy;
    assign o_res.in_cooldown     = r_in_cd;
    assign o_res.attempt_count   = r_count;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_started) |-> (r_busy && r_count != '0))
        else $error("started attempt not reported busy");

    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drop) |-> (!r_started && !r_busy))
        else $error("drop with start or busy");

    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_first) |=> (r_started_once && r_connecting))
        else $error("first start did not mark state");

    a_cd_from_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cooldown) |-> $past(w_fire && w_drop))
        else $error("cooldown began without a timeout");
`endif

endmodule

// File: tb/sv/link_reconnect_backoff_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect backoff controller checker
// Watches the configuration, input and result channels. Keeps its own copy
// of the controller state and registers, predicts one result per input beat
// and compares every result beat field by field against the oldest one.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_controller_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lrbc_in_if   i_in,
    lrbc_out_if  i_res,
    lrbc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic             accepted;
        logic             start_link;
        logic             first_start;
        logic             drop_link;
        logic             busy_connecting;
        logic             in_cooldown;
        lrbc_pkg::t_count attempt_count;
    } t_link_action;

    lrbc_pkg::t_time  cfg_timeout;
    lrbc_pkg::t_time  cfg_retry;
    lrbc_pkg::t_time  cfg_cooldown;
    lrbc_pkg::t_count cfg_limit;

    logic             busy;
    logic             ever_started;
    logic             cool_on;
    lrbc_pkg::t_time  attempt_t0;
    lrbc_pkg::t_time  last_try_t;
    lrbc_pkg::t_time  cool_t0;
    lrbc_pkg::t_count tries;

    t_link_action expected_actions[$];
    int           result_index;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] result %0d: %s", $time, result_index, msg);
    endtask

    function automatic logic launch_attempt(input lrbc_pkg::t_time now);
        logic first;
        first        = !ever_started;
        last_try_t   = now;
        attempt_t0   = now;
        busy         = 1'b1;
        if (tries != lrbc_pkg::COUNT_MAX) begin
            tries = tries + lrbc_pkg::t_count'(1);
        end
        ever_started = 1'b1;
        return first;
    endfunction

    function automatic t_link_action predict_link_step(input logic kind,
                                                       input lrbc_pkg::t_time now,
                                                       input logic up);
        t_link_action act;
        logic         hold;
        act  = '0;
        hold = 1'b0;
        if (kind == lrbc_pkg::KIND_REQUEST) begin
            if (!up && !busy) begin
                act.first_start = launch_attempt(now);
                act.accepted    = 1'b1;
            end
        end else if (up) begin
            busy    = 1'b0;
            tries   = '0;
            cool_on = 1'b0;
        end else if (busy) begin
            if (lrbc_pkg::t_time'(now - attempt_t0) >= cfg_timeout) begin
                act.drop_link = 1'b1;
                busy          = 1'b0;
                last_try_t    = now;
                if (tries >= cfg_limit) begin
                    cool_on = 1'b1;
                    cool_t0 = now;
                end
            end
        end else begin
            if (cool_on) begin
                if (lrbc_pkg::t_time'(now - cool_t0) < cfg_cooldown) begin
                    hold = 1'b1;
                end else begin
                    tries   = '0;
                    cool_on = 1'b0;
                end
            end
            if (!hold && lrbc_pkg::t_time'(now - last_try_t) >= cfg_retry) begin
                act.first_start = launch_attempt(now);
                act.accepted    = 1'b1;
            end
        end
        act.start_link      = act.accepted;
        act.busy_connecting = busy;
        act.in_cooldown     = cool_on;
        act.attempt_count   = tries;
        return act;
    endfunction

    always @(posedge i_clk) begin
        t_link_action want;
        if (!i_rst_n) begin
            cfg_timeout  = lrbc_pkg::RST_CONNECT_TIMEOUT;
            cfg_retry    = lrbc_pkg::RST_RETRY_INTERVAL;
            cfg_cooldown = lrbc_pkg::RST_COOLDOWN;
            cfg_limit    = lrbc_pkg::RST_ATTEMPT_LIMIT;
            busy         = 1'b0;
            ever_started = 1'b0;
            cool_on      = 1'b0;
            attempt_t0   = '0;
            last_try_t   = '0;
            cool_t0      = '0;
            tries        = '0;
            expected_actions.delete();
            result_index = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_idx)
                    lrbc_pkg::REG_CONNECT_TIMEOUT: cfg_timeout  = i_cfg.wdata;
                    lrbc_pkg::REG_RETRY_INTERVAL:  cfg_retry    = i_cfg.wdata;
                    lrbc_pkg::REG_COOLDOWN:        cfg_cooldown = i_cfg.wdata;
                    lrbc_pkg::REG_ATTEMPT_LIMIT:
                        cfg_limit = i_cfg.wdata[lrbc_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            // result beat is checked before the input beat of the same edge
            if (i_res.valid && i_res.ready) begin
                if (expected_actions.size() == 0) begin
                    report_mismatch("result beat with no input beat pending");
                end else begin
                    want = expected_actions.pop_front();
                    if (i_res.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %b want %b",
                                                  i_res.accepted, want.accepted));
                    if (i_res.start_link !== want.start_link)
                        report_mismatch($sformatf("start_link got %b want %b",
                                                  i_res.start_link, want.start_link));
                    if (i_res.first_start !== want.first_start)
                        report_mismatch($sformatf("first_start got %b want %b",
                                                  i_res.first_start, want.first_start));
                    if (i_res.drop_link !== want.drop_link)
                        report_mismatch($sformatf("drop_link got %b want %b",
                                                  i_res.drop_link, want.drop_link));
                    if (i_res.busy_connecting !== want.busy_connecting)
                        report_mismatch($sformatf("busy_connecting got %b want %b",
                                                  i_res.busy_connecting,
                                                  want.busy_connecting));
                    if (i_res.in_cooldown !== want.in_cooldown)
                        report_mismatch($sformatf("in_cooldown got %b want %b",
                                                  i_res.in_cooldown, want.in_cooldown));
                    if (i_res.attempt_count !== want.attempt_count)
                        report_mismatch($sformatf("attempt_count got %0d want %0d",
                                                  i_res.attempt_count, want.attempt_count));
                end
                result_index++;
            end
            if (i_in.valid && i_in.ready) begin
                expected_actions.push_back(predict_link_step(i_in.kind, i_in.now_ms,
                                                             i_in.link_up));
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

// File: tb/sv/link_reconnect_backoff_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link reconnect backoff controller testbench
// Drives directed and random poll/request beats through several register
// settings, with random idle bursts on both channels and one long result
// hold-off. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module link_reconnect_backoff_controller_tb;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int HOLD_CYCLES   = 64;
    localparam int QUIET_ITEMS   = 100;

    logic i_clk;
    logic i_rst_n;

    int   fail_count;
    int   pending;
    int   items_sent;
    int   cycle_count;
    bit   quiet;

    lrbc_in_if  link_in ();
    lrbc_out_if link_res ();
    lrbc_cfg_if link_cfg ();

    link_reconnect_backoff_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (link_in),
        .o_res   (link_res),
        .i_cfg   (link_cfg)
    );

    link_reconnect_backoff_controller_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (link_in),
        .i_res        (link_res),
        .i_cfg        (link_cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("link_reconnect_backoff_controller_tb NOT OK");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off to back up the input
    initial begin
        int  burst;
        bit  held;
        held = 1'b0;
        link_res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= HOLD_AT_ITEM) begin
                held = 1'b1;
                link_res.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 5);
                link_res.ready <= 1'b0;
                repeat (burst - 1) @(posedge i_clk);
            end else begin
                link_res.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic kind, input lrbc_pkg::t_time now,
                             input logic up);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            link_in.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        link_in.valid   <= 1'b1;
        link_in.kind    <= kind;
        link_in.now_ms  <= now;
        link_in.link_up <= up;
        @(posedge i_clk);
        while (!link_in.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic settle();
        link_in.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_field(input lrbc_pkg::t_reg_idx idx, input lrbc_pkg::t_time value);
        link_cfg.valid   <= 1'b1;
        link_cfg.reg_idx <= idx;
        link_cfg.wdata   <= value;
        @(posedge i_clk);
        while (!link_cfg.ready) @(posedge i_clk);
    endtask

    task automatic load_config(input lrbc_pkg::t_time tmo, input lrbc_pkg::t_time retry,
                               input lrbc_pkg::t_time cool, input lrbc_pkg::t_count lim);
        write_field(lrbc_pkg::REG_CONNECT_TIMEOUT, tmo);
        write_field(lrbc_pkg::REG_RETRY_INTERVAL, retry);
        write_field(lrbc_pkg::REG_COOLDOWN, cool);
        write_field(lrbc_pkg::REG_ATTEMPT_LIMIT, lrbc_pkg::t_time'(lim));
        link_cfg.valid <= 1'b0;
    endtask

    // link state toggles now and then; time moves forward by random steps
    task automatic run_mixed_phase(input int count, input int unsigned step_max);
        lrbc_pkg::t_time clock_ms;
        logic            up;
        int              i;
        clock_ms = $urandom();
        up       = 1'b0;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 11) == 0) up = ~up;
            clock_ms += $urandom_range(0, step_max);
            send_item(($urandom_range(0, 4) == 0) ? lrbc_pkg::KIND_REQUEST
                                                  : lrbc_pkg::KIND_POLL,
                      clock_ms, up);
        end
        settle();
    endtask

    // request/poll pairs with instant timeouts drive the count up to saturation
    task automatic run_saturation_phase(input int count);
        logic kind;
        int   i;
        send_item(lrbc_pkg::KIND_POLL, $urandom(), 1'b1);
        for (i = 0; i < count; i++) begin
            kind = (i % 2 == 0) ? lrbc_pkg::KIND_REQUEST : lrbc_pkg::KIND_POLL;
            if ($urandom_range(0, 15) == 0) kind = ~kind;
            if (i >= count - QUIET_ITEMS) quiet = 1'b1;
            send_item(kind, $urandom(), 1'b0);
        end
        settle();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        quiet            = 1'b0;
        items_sent       = 0;
        cycle_count      = 0;
        link_in.valid   <= 1'b0;
        link_in.kind    <= lrbc_pkg::KIND_POLL;
        link_in.now_ms  <= '0;
        link_in.link_up <= 1'b0;
        link_cfg.valid  <= 1'b0;
        link_cfg.reg_idx <= lrbc_pkg::REG_CONNECT_TIMEOUT;
        link_cfg.wdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults
        send_item(lrbc_pkg::KIND_POLL,    32'd0,          1'b0);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd0,          1'b1);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd100,        1'b0);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd200,        1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd10100,      1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd15100,      1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd15100,      1'b1);
        send_item(lrbc_pkg::KIND_POLL,    32'hFFFF_FFFF,  1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd9998,       1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd9999,       1'b0);
        settle();

        // zero limit: every timeout opens a cooldown, first one at time zero
        load_config(32'd0, 32'd0, 32'd100, 8'd0);
        send_item(lrbc_pkg::KIND_POLL,    32'd0,   1'b1);
        send_item(lrbc_pkg::KIND_POLL,    32'd0,   1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd0,   1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd50,  1'b0);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd60,  1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd60,  1'b0);
        send_item(lrbc_pkg::KIND_POLL,    32'd160, 1'b0);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd170, 1'b1);
        send_item(lrbc_pkg::KIND_POLL,    32'd170, 1'b0);
        send_item(lrbc_pkg::KIND_REQUEST, 32'd171, 1'b1);
        settle();

        load_config(32'd0, 32'd0, 32'd0, 8'd0);
        run_mixed_phase(30, 4);
        repeat (3) begin
            load_config($urandom_range(5, 40), $urandom_range(0, 30),
                        $urandom_range(0, 200),
                        lrbc_pkg::t_count'($urandom_range(0, 4)));
            run_mixed_phase(35, 15);
        end
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, lrbc_pkg::COUNT_MAX);
        run_mixed_phase(30, 32'hFFFF_FFFF);
        load_config(32'd0, 32'd0, 32'hFFFF_FFFF, lrbc_pkg::COUNT_MAX);
        run_saturation_phase(580);

        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("link_reconnect_backoff_controller_tb OK");
        end else begin
            $display("link_reconnect_backoff_controller_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/lrbc_pkg.sv
sv/lrbc_if.sv
sv/link_reconnect_backoff_controller.sv
tb/sv/link_reconnect_backoff_controller_checker.sv
tb/sv/link_reconnect_backoff_controller_tb.sv
